FILE: sv/clpa_pkg.sv
`default_nettype none
package clpa_pkg;
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_TOO_BIG  = 2'd1,
        ST_NO_PAGE  = 2'd2,
        ST_BAD_FREE = 2'd3
    } status_t;

    localparam int ADDR_W  = 24;
    localparam int SIZE_W  = 16;
    localparam int COUNT_W = 16;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // controller to datapath
    typedef struct packed {
        logic cnt_rd;       // read count of cnt_sel page
        logic [1:0] cnt_sel; // 0 cur ring page, 1 next ring page, 2 free page, 3 fifo head
        logic cnt_inc;      // write count+1 (saturating)
        logic cnt_dec;      // write count-1
        logic fifo_rd;      // read fifo head
        logic rotate;       // pop head, push to tail
        logic adv_slot;     // move to next ring slot
        logic take_head;    // pop head into ring, push old
        logic take_fresh;   // fresh page into ring, push old
        logic do_alloc;     // bump and form address
        logic load;         // capture request
        logic present;      // copy result into output register
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic is_free;
        logic too_big;
        logic fits;
        logic cnt_zero;
        logic free_bad_page;
        logic fifo_empty;
        logic fifo_full;
        logic fresh_left;
        logic clearing;
    } sts_t;
endpackage
`default_nettype wire

FILE: sv/cache_line_page_allocator.sv
// path from accept to result: oversize S_DECODE, S_OUT; free S_DECODE, S_FREECHK, S_OUT;
// allocate that fits S_DECODE, S_ALLOCRD, S_ALLOCWR, S_OUT; moving to the next ring page
// adds S_CHKNXT; pending fifo rollover also adds S_SCANRD, S_SCANCNT, S_SCANCHK per page
// checked and S_NXTWAIT; out of pages ends S_NXTWAIT, S_OUT. One word at a time, next
// word taken once the result is registered; reset: asynchronous active low, ring pages
// 0..RING_PAGES-1, fifo empty; counts are cleared one per cycle after reset, input held off
`default_nettype none
module cache_line_page_allocator #(
    parameter int NUM_PAGES      = 256,
    parameter int RING_PAGES     = 4,
    parameter int LINES_PER_PAGE = 1024,
    parameter int LINE_BYTES     = 64,
    parameter int HEADER_LINES   = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // size_bytes[15:0], free_address[39:16]
    input  wire logic        s_tuser,   // req_type
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata    // address[23:0], status[25:24], zero fill
);
    import clpa_pkg::*;

    cmd_t cmd;
    sts_t sts;
    logic [23:0] addr;
    logic [1:0]  status;
    logic        ok;
    logic [$clog2(NUM_PAGES):0] pend_count;

    clpa_datapath #(
        .NUM_PAGES(NUM_PAGES), .RING_PAGES(RING_PAGES),
        .LINES_PER_PAGE(LINES_PER_PAGE), .LINE_BYTES(LINE_BYTES),
        .HEADER_LINES(HEADER_LINES)
    ) u_dp (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .sts(sts), .pend_count(pend_count),
        .in_req(s_tuser), .in_size(s_tdata[15:0]), .in_faddr(s_tdata[39:16]),
        .res_addr(addr)
    );

    clpa_ctrl #(.NUM_PAGES(NUM_PAGES)) u_ctrl (
        .clk(clk), .rst_n(rst_n),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .res_status(status), .addr_sel(ok), .cmd(cmd), .sts(sts),
        .pend_count(pend_count)
    );

    assign m_tdata = {6'd0, status, ok ? addr : 24'd0};
endmodule
`default_nettype wire

FILE: sv/clpa_datapath.sv
`default_nettype none
module clpa_datapath #(
    parameter int NUM_PAGES      = 256,
    parameter int RING_PAGES     = 4,
    parameter int LINES_PER_PAGE = 1024,
    parameter int LINE_BYTES     = 64,
    parameter int HEADER_LINES   = 2
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire clpa_pkg::cmd_t     cmd,
    output clpa_pkg::sts_t          sts,
    output logic [$clog2(NUM_PAGES):0] pend_count,
    input  wire logic               in_req,
    input  wire logic [15:0]        in_size,
    input  wire logic [23:0]        in_faddr,
    output logic [23:0]             res_addr
);
    import clpa_pkg::*;

    localparam int PW  = $clog2(NUM_PAGES);
    localparam int RW  = $clog2(RING_PAGES);
    localparam int LW  = $clog2(LINES_PER_PAGE + 1);
    localparam int OW  = $clog2(LINE_BYTES);
    localparam int PLW = $clog2(LINES_PER_PAGE);
    localparam int PCW = PW + 1;
    localparam int SLW = SIZE_W - OW + 1;
    localparam int ASH = OW + PLW;

    logic [COUNT_W-1:0] cnt_mem [NUM_PAGES];
    logic [PW-1:0]      fifo_mem [NUM_PAGES];
    logic [PW-1:0]      ring_reg [RING_PAGES];
    logic [PW-1:0]      ring_next [RING_PAGES];

    logic [RW-1:0]  slot_reg, slot_next;
    logic [LW-1:0]  used_reg, used_next;
    logic [PW-1:0]  head_reg, head_next;
    logic [PCW-1:0] pcnt_reg, pcnt_next;
    logic [PCW-1:0] fresh_reg, fresh_next;
    logic [PCW-1:0] clr_reg;
    logic           req_reg;
    logic [SLW-1:0] lines_reg;
    logic [23:0]    faddr_reg;
    logic [PW-1:0]  sel_reg;
    logic [COUNT_W-1:0] cnt_q;
    logic [PW-1:0]  fifo_q;
    logic [23:0]    addr_reg;
    logic [23:0]    res_addr_reg;

    logic [RW-1:0]  slot_nx;
    logic [PW-1:0]  tail;
    logic [PW-1:0]  sel_page;
    logic [SLW-1:0] lines_c;
    logic [23:0]    base;
    logic           fpage_bad;
    logic           clearing;

    assign slot_nx = (RW'(slot_reg) == RW'(RING_PAGES - 1)) ? '0 : slot_reg + 1'b1;
    assign tail    = head_reg + pcnt_reg[PW-1:0];
    assign lines_c = SLW'((17'(in_size) + 17'(LINE_BYTES - 1)) >> OW);
    assign fpage_bad = (32'(faddr_reg >> ASH) >= 32'(NUM_PAGES));
    assign clearing  = (32'(clr_reg) < NUM_PAGES);

    // page select for count access
    always_comb
    begin
        case (cmd.cnt_sel)
            2'd0:    sel_page = ring_reg[slot_reg];
            2'd1:    sel_page = ring_reg[slot_nx];
            2'd2:    sel_page = PW'(faddr_reg >> ASH);
            default: sel_page = fifo_q;
        endcase
    end

    // status back to controller
    assign sts.is_free       = req_reg;
    assign sts.too_big       = (32'(lines_reg) + HEADER_LINES) > LINES_PER_PAGE;
    assign sts.fits          = (32'(used_reg) + 32'(lines_reg)) <= LINES_PER_PAGE;
    assign sts.cnt_zero      = (cnt_q == '0);
    assign sts.free_bad_page = fpage_bad;
    assign sts.fifo_empty    = (pcnt_reg == '0);
    assign sts.fifo_full     = (32'(pcnt_reg) >= NUM_PAGES);
    assign sts.fresh_left    = (32'(fresh_reg) < NUM_PAGES);
    assign sts.clearing      = clearing;
    assign pend_count        = pcnt_reg;

    assign base = 24'(32'(ring_reg[slot_reg]) << ASH);

    // count and fifo memories, counts zeroed one per cycle after reset
    always_ff @(posedge clk)
    begin
        if (cmd.cnt_rd)
        begin
            cnt_q   <= cnt_mem[sel_page];
            sel_reg <= sel_page;
        end
        if (clearing)
            cnt_mem[clr_reg[PW-1:0]] <= '0;
        else if (cmd.cnt_inc && cnt_q != COUNT_MAX)
            cnt_mem[sel_reg] <= cnt_q + 1'b1;
        else if (cmd.cnt_dec)
            cnt_mem[sel_reg] <= cnt_q - 1'b1;
        if (cmd.fifo_rd)
            fifo_q <= fifo_mem[head_reg];
        if (cmd.rotate)
            fifo_mem[tail] <= fifo_q;
        else if (cmd.take_head || cmd.take_fresh)
            fifo_mem[tail] <= ring_reg[slot_reg];
        if (cmd.load)
        begin
            lines_reg <= lines_c;
            faddr_reg <= in_faddr;
        end
        if (cmd.do_alloc)
            addr_reg <= base + 24'(32'(used_reg) << OW);
        if (cmd.present)
            res_addr_reg <= addr_reg;
    end

    // pointer state next values
    always_comb
    begin
        slot_next  = slot_reg;
        used_next  = used_reg;
        head_next  = head_reg;
        pcnt_next  = pcnt_reg;
        fresh_next = fresh_reg;
        for (int i = 0; i < RING_PAGES; i++)
            ring_next[i] = ring_reg[i];
        if (cmd.adv_slot)
        begin
            slot_next = slot_nx;
            used_next = LW'(HEADER_LINES);
        end
        if (cmd.rotate)
            head_next = head_reg + 1'b1;
        if (cmd.take_head)
        begin
            ring_next[slot_reg] = fifo_q;
            head_next = head_reg + 1'b1;
            used_next = LW'(HEADER_LINES);
        end
        if (cmd.take_fresh)
        begin
            ring_next[slot_reg] = fresh_reg[PW-1:0];
            fresh_next = fresh_reg + 1'b1;
            pcnt_next  = pcnt_reg + 1'b1;
            used_next  = LW'(HEADER_LINES);
        end
        if (cmd.do_alloc)
            used_next = used_reg + LW'(lines_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg  <= '0;
            used_reg  <= LW'(HEADER_LINES);
            head_reg  <= '0;
            pcnt_reg  <= '0;
            fresh_reg <= PCW'(RING_PAGES);
            clr_reg   <= '0;
            req_reg   <= 1'b0;
            for (int i = 0; i < RING_PAGES; i++)
                ring_reg[i] <= PW'(i);
        end
        else
        begin
            slot_reg  <= slot_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            pcnt_reg  <= pcnt_next;
            fresh_reg <= fresh_next;
            if (clearing)
                clr_reg <= clr_reg + 1'b1;
            for (int i = 0; i < RING_PAGES; i++)
                ring_reg[i] <= ring_next[i];
            if (cmd.load)
                req_reg <= in_req;
        end
    end

    assign res_addr = res_addr_reg;
endmodule
`default_nettype wire

FILE: sv/clpa_ctrl.sv
`default_nettype none
module clpa_ctrl #(
    parameter int NUM_PAGES = 256
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  wire logic           out_ready,
    output logic [1:0]          res_status,
    output logic                addr_sel,
    output clpa_pkg::cmd_t      cmd,
    input  wire clpa_pkg::sts_t sts,
    input  wire logic [$clog2(NUM_PAGES):0] pend_count
);
    import clpa_pkg::*;

    localparam int PCW = $clog2(NUM_PAGES) + 1;

    typedef enum logic [3:0] {
        S_IDLE, S_DECODE, S_CHKNXT, S_NXTWAIT, S_SCANRD, S_SCANCNT, S_SCANCHK,
        S_ALLOCRD, S_ALLOCWR, S_FREECHK, S_OUT
    } state_t;

    state_t state_reg;
    logic [PCW-1:0] k_reg;
    logic [PCW-1:0] n_reg;
    logic found_reg;
    logic [1:0] status_reg;
    logic ok_reg;
    logic [1:0] res_status_reg;
    logic res_ok_reg;

    assign in_ready   = (state_reg == S_IDLE) && !sts.clearing;
    assign res_status = res_status_reg;
    assign addr_sel   = res_ok_reg;

    // command decode per state
    always_comb
    begin
        cmd = '0;
        case (state_reg)
            S_IDLE:    cmd.load = in_valid && in_ready;
            S_DECODE:
            begin
                cmd.cnt_rd  = 1'b1;
                cmd.cnt_sel = sts.is_free ? 2'd2 : (sts.fits ? 2'd0 : 2'd1);
            end
            S_SCANRD:  cmd.fifo_rd = 1'b1;
            S_SCANCNT: begin cmd.cnt_rd = 1'b1; cmd.cnt_sel = 2'd3; end
            S_SCANCHK: cmd.rotate = !sts.cnt_zero;
            S_ALLOCRD: begin cmd.cnt_rd = 1'b1; cmd.cnt_sel = 2'd0; end
            S_ALLOCWR: begin cmd.cnt_inc = 1'b1; cmd.do_alloc = 1'b1; end
            S_OUT:     cmd.present = !out_valid || out_ready;
            default:   ;
        endcase
        if (state_reg == S_CHKNXT)
        begin
            cmd.adv_slot = sts.cnt_zero;
        end
        if (state_reg == S_NXTWAIT)
        begin
            cmd.take_head  = found_reg;
            cmd.take_fresh = !found_reg && sts.fresh_left && !sts.fifo_full;
        end
        if (state_reg == S_FREECHK)
            cmd.cnt_dec = !(sts.free_bad_page || sts.cnt_zero);
    end

    // state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid      <= 1'b0;
            status_reg     <= ST_OK;
            ok_reg         <= 1'b0;
            res_status_reg <= ST_OK;
            res_ok_reg     <= 1'b0;
            k_reg          <= '0;
            n_reg          <= '0;
            found_reg      <= 1'b0;
        end
        else
        begin
            // output register, refilled as it empties
            if (cmd.present)
                out_valid <= 1'b1;
            else if (out_ready)
                out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                    if (in_valid && in_ready)
                        state_reg <= S_DECODE;
                S_DECODE:
                    if (sts.is_free)
                        state_reg <= S_FREECHK;
                    else if (sts.too_big)
                    begin
                        status_reg <= ST_TOO_BIG;
                        ok_reg     <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                    else if (sts.fits)
                        state_reg <= S_ALLOCRD;
                    else
                        state_reg <= S_CHKNXT;
                S_CHKNXT:
                begin
                    found_reg <= 1'b0;
                    k_reg     <= '0;
                    n_reg     <= pend_count;
                    if (sts.cnt_zero)
                        state_reg <= S_ALLOCRD;
                    else if (sts.fifo_empty)
                        state_reg <= S_NXTWAIT;
                    else
                        state_reg <= S_SCANRD;
                end
                S_SCANRD:  state_reg <= S_SCANCNT;
                S_SCANCNT: state_reg <= S_SCANCHK;
                S_SCANCHK:
                    if (sts.cnt_zero)
                    begin
                        found_reg <= 1'b1;
                        state_reg <= S_NXTWAIT;
                    end
                    else if (k_reg + 1'b1 == n_reg)
                        state_reg <= S_NXTWAIT;
                    else
                    begin
                        k_reg     <= k_reg + 1'b1;
                        state_reg <= S_SCANRD;
                    end
                S_NXTWAIT:
                    if (found_reg || (sts.fresh_left && !sts.fifo_full))
                        state_reg <= S_ALLOCRD;
                    else
                    begin
                        status_reg <= ST_NO_PAGE;
                        ok_reg     <= 1'b0;
                        state_reg  <= S_OUT;
                    end
                S_ALLOCRD: state_reg <= S_ALLOCWR;
                S_ALLOCWR:
                begin
                    status_reg <= ST_OK;
                    ok_reg     <= 1'b1;
                    state_reg  <= S_OUT;
                end
                S_FREECHK:
                begin
                    status_reg <= (sts.free_bad_page || sts.cnt_zero) ? ST_BAD_FREE : ST_OK;
                    ok_reg     <= 1'b0;
                    state_reg  <= S_OUT;
                end
                S_OUT:
                    if (cmd.present)
                    begin
                        res_status_reg <= status_reg;
                        res_ok_reg     <= ok_reg;
                        state_reg      <= S_IDLE;
                    end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |=> out_valid)
        else $error("result not presented");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(res_status) && $stable(addr_sel))
        else $error("result changed while waiting");
endmodule
`default_nettype wire

FILE: tb/sv/clpa_checker.sv
`timescale 1ns / 100ps
module clpa_checker
    import clpa_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [39:0] s_tdata,   // size_bytes[15:0], free_address[39:16]
    input  wire logic        s_tuser,   // req_type
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,   // address[23:0], status[25:24], zero fill
    output int               fail_count,
    output int               words_owed
);
    localparam int N_PAGES    = 256;
    localparam int N_RING     = 4;
    localparam int PAGE_LINES = 1024;
    localparam int LINE_SZ    = 64;
    localparam int HDR_LINES  = 2;
    localparam int PAGE_SZ    = PAGE_LINES * LINE_SZ;

    typedef enum bit {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_t;

    typedef struct {
        logic [ADDR_W-1:0] address;
        status_t           status;
    } grant_t;

    // allocator state mirror
    logic [COUNT_W-1:0] live_cnt [N_PAGES];
    logic [7:0]         ring_pg  [N_RING];
    int                 cur_slot;
    int                 bump_line;
    logic [7:0]         spare_q  [N_PAGES];
    int                 spare_head;
    int                 spare_len;
    int                 fresh_pg;

    grant_t             grants_due [$];

    assign words_owed = grants_due.size();

    function automatic logic [7:0] spare_pop();
        logic [7:0] v;
        v = spare_q[spare_head];
        spare_head = (spare_head + 1) % N_PAGES;
        spare_len--;
        return v;
    endfunction

    function automatic void spare_push(logic [7:0] v);
        spare_q[(spare_head + spare_len) % N_PAGES] = v;
        spare_len++;
    endfunction

    // move to a new page; returns 0 when none can be had, state then untouched
    function automatic bit page_roll();
        int         nxt;
        int         k;
        int         n;
        bit         hit;
        logic [7:0] prev;
        nxt = (cur_slot + 1) % N_RING;
        hit = 0;
        n = spare_len;
        if (live_cnt[ring_pg[nxt]] == 0) begin
            cur_slot = nxt;
            bump_line = HDR_LINES;
            return 1;
        end
        for (k = 0; k < n; k++) begin
            if (live_cnt[spare_q[(spare_head + k) % N_PAGES]] == 0) begin
                hit = 1;
                break;
            end
        end
        if (!hit && (fresh_pg >= N_PAGES || spare_len >= N_PAGES))
            return 0;
        prev = ring_pg[cur_slot];
        if (hit) begin
            for (int i = 0; i < k; i++)
                spare_push(spare_pop());
            ring_pg[cur_slot] = spare_pop();
        end
        else begin
            ring_pg[cur_slot] = fresh_pg[7:0];
            fresh_pg++;
        end
        spare_push(prev);
        bump_line = HDR_LINES;
        return 1;
    endfunction

    function automatic grant_t serve_request(req_t kind, logic [15:0] nbytes,
                                             logic [23:0] rel_addr);
        grant_t g;
        int     lines;
        int     pg;
        g.address = '0;
        g.status = ST_OK;
        if (kind == REQ_ALLOC) begin
            lines = (int'(nbytes) + LINE_SZ - 1) / LINE_SZ;
            if (lines + HDR_LINES > PAGE_LINES)
                g.status = ST_TOO_BIG;
            else if (bump_line + lines > PAGE_LINES && !page_roll())
                g.status = ST_NO_PAGE;
            else begin
                pg = ring_pg[cur_slot];
                if (live_cnt[pg] != COUNT_MAX)
                    live_cnt[pg]++;
                g.address = ADDR_W'(pg * PAGE_SZ + bump_line * LINE_SZ);
                bump_line += lines;
            end
        end
        else begin
            pg = int'(rel_addr) / PAGE_SZ;
            if (pg >= N_PAGES || live_cnt[pg] == 0)
                g.status = ST_BAD_FREE;
            else
                live_cnt[pg]--;
        end
        return g;
    endfunction

    // predict on each accepted request, compare each delivered result
    always @(posedge clk or negedge rst_n)
    begin
        grant_t  want;
        status_t got_st;
        if (!rst_n) begin
            for (int i = 0; i < N_PAGES; i++)
            begin
                live_cnt[i] = '0;
                spare_q[i] = '0;
            end
            for (int i = 0; i < N_RING; i++)
                ring_pg[i] = 8'(i);
            cur_slot = 0;
            bump_line = HDR_LINES;
            spare_head = 0;
            spare_len = 0;
            fresh_pg = N_RING;
            fail_count = 0;
            grants_due.delete();
        end
        else begin
            if (m_tvalid && m_tready) begin
                got_st = status_t'(m_tdata[25:24]);
                if (grants_due.size() == 0) begin
                    $display("%0t: unexpected word addr %h status %s", $time,
                             m_tdata[23:0], got_st.name());
                    fail_count++;
                end
                else begin
                    want = grants_due.pop_front();
                    if (m_tdata[23:0] !== want.address) begin
                        $display("%0t: address expected %h actual %h", $time,
                                 want.address, m_tdata[23:0]);
                        fail_count++;
                    end
                    if (m_tdata[25:24] !== want.status) begin
                        $display("%0t: status expected %s actual %s", $time,
                                 want.status.name(), got_st.name());
                        fail_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                grants_due.push_back(serve_request(req_t'(s_tuser), s_tdata[15:0],
                                                   s_tdata[39:16]));
        end
    end
endmodule

FILE: tb/sv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
    import clpa_pkg::*;

    typedef enum bit {REQ_ALLOC = 1'b0, REQ_FREE = 1'b1} req_t;

    localparam int  RAND_WORDS  = 1400;
    localparam int  CYCLE_LIMIT = 4000000;
    localparam int  FULL_PAGE   = 65408;    // 1022 lines, fills a fresh page

    logic        clk = 0;
    logic        rst_n = 0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        s_tuser = 0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [31:0] m_tdata;
    int          fail_count;
    int          words_owed;
    int          cycles = 0;
    bit          calm = 0;
    logic [23:0] live_addr [$];
    req_t        sent_kind [$];

    cache_line_page_allocator dut (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    clpa_checker chk (
        .clk(clk), .rst_n(rst_n),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .fail_count(fail_count), .words_owed(words_owed)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // quiet stretches with no idling on either side
    always @(negedge clk)
        if ($urandom_range(0, 499) == 0)
            calm = ~calm;

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // result side stalls
    always @(negedge clk)
    begin
        int hold;
        if (hold > 0) begin
            hold--;
            m_tready = 0;
        end
        else begin
            hold = gap_len();
            m_tready = (hold == 0);
        end
    end

    // remember live allocations so frees can target them
    always @(posedge clk)
    begin
        req_t k;
        if (rst_n) begin
            if (m_tvalid && m_tready && sent_kind.size() != 0) begin
                k = sent_kind.pop_front();
                if (k == REQ_ALLOC && m_tdata[25:24] == ST_OK)
                    live_addr.push_back(m_tdata[23:0]);
            end
            if (s_tvalid && s_tready)
                sent_kind.push_back(req_t'(s_tuser));
        end
    end

    // one request word, then an optional gap
    task automatic send_word(req_t kind, logic [15:0] nbytes, logic [23:0] rel_addr,
                             bit allow_gap);
        int g;
        s_tvalid = 1;
        s_tuser = kind;
        s_tdata = {rel_addr, nbytes};
        do @(posedge clk); while (!s_tready);
        @(negedge clk);
        g = allow_gap ? gap_len() : 0;
        if (g > 0) begin
            s_tvalid = 0;
            s_tdata = 40'({$urandom, $urandom});
            repeat (g) @(negedge clk);
        end
    endtask

    task automatic free_live();
        int idx;
        logic [23:0] a;
        if (live_addr.size() == 0) begin
            send_word(REQ_FREE, 16'($urandom), 24'($urandom), 1);
            return;
        end
        idx = $urandom_range(0, live_addr.size() - 1);
        a = live_addr[idx];
        live_addr.delete(idx);
        send_word(REQ_FREE, 16'($urandom), a, 1);
    endtask

    task automatic alloc_random();
        int r;
        logic [15:0] sz;
        r = $urandom_range(0, 99);
        if (r < 50)
            sz = 16'($urandom_range(0, 511));
        else if (r < 80)
            sz = 16'($urandom_range(0, FULL_PAGE));
        else if (r < 90)
            sz = ($urandom_range(0, 1) != 0) ? 16'd0 : 16'(FULL_PAGE);
        else
            sz = 16'($urandom_range(FULL_PAGE + 1, 65535));
        send_word(REQ_ALLOC, sz, 24'($urandom), 1);
    endtask

    initial begin
        int r;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1;
        repeat (2) @(negedge clk);

        // directed: size extremes, line rounding, oversize, zero-count free
        send_word(REQ_ALLOC, 16'd0, '0, 1);
        send_word(REQ_ALLOC, 16'd1, '1, 1);
        send_word(REQ_ALLOC, 16'd64, '0, 1);
        send_word(REQ_ALLOC, 16'd65, '0, 1);
        send_word(REQ_ALLOC, 16'(FULL_PAGE), '0, 1);
        send_word(REQ_ALLOC, 16'(FULL_PAGE + 1), '0, 1);
        send_word(REQ_ALLOC, 16'hFFFF, '0, 1);
        send_word(REQ_FREE, 16'hFFFF, 24'd200 << 16, 1);
        send_word(REQ_FREE, '0, 24'hFFFFFF, 1);
        send_word(REQ_FREE, '0, 24'h000040, 1);
        send_word(REQ_FREE, '0, 24'h000040, 1);
        send_word(REQ_ALLOC, 16'd4096, '0, 1);
        free_live();

        // full-page allocations until fresh pages run out
        repeat (270) send_word(REQ_ALLOC, 16'(FULL_PAGE), 24'($urandom), 1);

        // random mix, frees mostly of live allocations
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 45)
                alloc_random();
            else if (r < 87)
                free_live();
            else
                send_word(REQ_FREE, 16'($urandom), 24'($urandom), 1);
        end

        s_tvalid = 0;
        wait (words_owed == 0);
        repeat (50) @(posedge clk);
        if (fail_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

FILE: cache_line_page_allocator.f
sv/clpa_pkg.sv
sv/clpa_datapath.sv
sv/clpa_ctrl.sv
sv/cache_line_page_allocator.sv
tb/sv/clpa_checker.sv
tb/sv/tb_top.sv
